// ----- hw/rtl/joystick_axis_to_step_rate_top_macros.svh -----
// Assertion helpers shared by the joystick step-rate RTL.
// Each expects clk and rst_n in scope of the using module.
`ifndef JOYSTICK_AXIS_TO_STEP_RATE_TOP_MACROS_SVH
`define JOYSTICK_AXIS_TO_STEP_RATE_TOP_MACROS_SVH

// Same-cycle implication, switched off while reset is held
`define JSR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held
`define JSR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/jsr_pkg.sv -----
`default_nettype none

package jsr_pkg;

  // Sample averaging
  localparam int SAMPLE_W            = 12;
  localparam int SAMPLES_PER_READING = 8;
  localparam int SAMPLE_SHIFT        = 3;
  localparam int SUM_W               = SAMPLE_W + SAMPLE_SHIFT;
  localparam int IDX_W               = 3;
  localparam logic [SAMPLE_W-1:0] ADC_MAX = 12'hFFF;

  // Calibration
  localparam int CAL_READINGS = 25;
  localparam int CAL_SUM_W    = 17;
  localparam int CAL_IDX_W    = 5;
  localparam int TRAVEL_W     = 13;

  // Register widths
  localparam int DZ_W  = 11;
  localparam int IVL_W = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOWEST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FASTEST   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT    = 2'd3;

  // Register reset values
  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST = 11'd400;
  localparam logic [IVL_W-1:0] SLOWEST_RST   = 16'd6000;
  localparam logic [IVL_W-1:0] FASTEST_RST   = 16'd1200;

  // Divider geometry: range (16 b) times clamped travel (11 b)
  localparam int DVD_W     = 27;
  localparam int DVS_W     = 11;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/jsr_div.sv -----
`default_nettype none

// Restoring divider, one quotient bit per cycle
module jsr_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire jsr_pkg::div_req_t req,
  output jsr_pkg::div_rsp_t     rsp
);

  logic [jsr_pkg::DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [jsr_pkg::DVS_W-1:0]     dvs_r, dvs_nxt;
  logic [jsr_pkg::DVS_W-1:0]     rem_r, rem_nxt;
  logic [jsr_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [jsr_pkg::DVS_W:0]       rem_sh;
  logic                          ge;

  // Shift in the next dividend bit and trial-subtract
  always_comb begin
    rem_sh   = {rem_r, dvd_r[jsr_pkg::DVD_W-1]};
    ge       = (rem_sh >= {1'b0, dvs_r});
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      dvd_nxt  = req.dividend;
      dvs_nxt  = req.divisor;
      rem_nxt  = '0;
      cnt_nxt  = jsr_pkg::DIV_CNT_W'(jsr_pkg::DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? jsr_pkg::DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[jsr_pkg::DVS_W-1:0];
      dvd_nxt = {dvd_r[jsr_pkg::DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == jsr_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

`default_nettype wire

// ----- hw/rtl/joystick_axis_to_step_rate_top.sv -----
`default_nettype none
// Joystick axis to step-rate mapper.
// in_*  : one raw 12-bit converter sample per request. Every eight samples form
//         one averaged reading. The first 25 readings after reset calibrate the
//         centre and give no result; each later reading gives one out_ request.
// out_* : moving, forward, interval_us, motion_changed, travel_fault.
// cfg_* : register writes (dead zone, slowest, fastest, invert), always ready;
//         write them only while no reading is in progress.
// Flow: samples that do not close a group are taken without a stall, as are the
// closing samples of the first 24 calibration readings. Any other eighth sample
// holds in_tready low while the reading is processed: evaluate and write back
// when the stick is inside the dead zone or travel is faulty; evaluate, clamp,
// multiply, divide in the bit-serial divider and write back when moving; and the
// centre division at the end of calibration. The divider is shared by both uses.
// Output: one register; a stalled result holds until out_tready, and the block
// keeps taking samples meanwhile, stalling only when the next result is ready.
// Reset (rst_n low, synchronous) clears all sums, the calibration and the
// output, and restores the register defaults.
`include "joystick_axis_to_step_rate_top_macros.svh"

module joystick_axis_to_step_rate_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [11:0] adc_sample
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [0] moving, [1] forward, [17:2] interval_us,
                                       // [18] motion_changed, [19] travel_fault
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [jsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EVAL = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_WB   = 3'd5;

  // Configuration
  logic [jsr_pkg::DZ_W-1:0]  dead_zone_r;
  logic [jsr_pkg::IVL_W-1:0] slowest_r;
  logic [jsr_pkg::IVL_W-1:0] fastest_r;
  logic                      invert_r;

  // Sequencer and state
  logic [2:0]                         state_r, state_nxt;
  logic [jsr_pkg::SUM_W-1:0]          sum_r, sum_nxt;
  logic [jsr_pkg::IDX_W-1:0]          idx_r, idx_nxt;
  logic [jsr_pkg::CAL_SUM_W-1:0]      cal_sum_r, cal_sum_nxt;
  logic [jsr_pkg::CAL_IDX_W-1:0]      cal_idx_r, cal_idx_nxt;
  logic                               calibrated_r, calibrated_nxt;
  logic [jsr_pkg::SAMPLE_W-1:0]       centre_r, centre_nxt;
  logic signed [jsr_pkg::TRAVEL_W-1:0] travel_r, travel_nxt;
  logic                               was_moving_r, was_moving_nxt;
  logic                               div_cal_r, div_cal_nxt;
  jsr_pkg::div_req_t                  div_req_r, div_req_nxt;
  jsr_pkg::div_rsp_t                  div_rsp;

  // Per-reading working registers
  logic [jsr_pkg::SAMPLE_W-1:0] reading_r, reading_nxt;
  logic [jsr_pkg::SAMPLE_W-1:0] defl_r, defl_nxt;
  logic [jsr_pkg::DVS_W-1:0]    clamped_r, clamped_nxt;
  logic                         mov_r, mov_nxt;
  logic                         fwd_r, fwd_nxt;
  logic                         fault_r, fault_nxt;
  logic [jsr_pkg::IVL_W-1:0]    ivl_r, ivl_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic                      out_moving_r, out_fwd_r, out_chg_r, out_fault_r;
  logic [jsr_pkg::IVL_W-1:0] out_ivl_r;
  logic                      out_load;

  // Combinational helpers
  logic                           in_acc;
  logic [jsr_pkg::SUM_W-1:0]      sample_sum;
  logic [jsr_pkg::SAMPLE_W-1:0]   reading;
  logic [jsr_pkg::CAL_SUM_W-1:0]  cal_add;
  logic signed [jsr_pkg::TRAVEL_W-1:0] offset;
  logic [jsr_pkg::SAMPLE_W-1:0]   defl;
  logic                           fault, moving;
  logic [jsr_pkg::SAMPLE_W-1:0]   beyond;
  logic [jsr_pkg::SAMPLE_W-1:0]   other, short_side;
  logic [jsr_pkg::IVL_W-1:0]      range;
  logic [jsr_pkg::SAMPLE_W-1:0]   centre_q;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r <= jsr_pkg::DEAD_ZONE_RST;
      slowest_r   <= jsr_pkg::SLOWEST_RST;
      fastest_r   <= jsr_pkg::FASTEST_RST;
      invert_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jsr_pkg::REG_DEAD_ZONE: dead_zone_r <= cfg_data[jsr_pkg::DZ_W-1:0];
        jsr_pkg::REG_SLOWEST:   slowest_r   <= cfg_data;
        jsr_pkg::REG_FASTEST:   fastest_r   <= cfg_data;
        jsr_pkg::REG_INVERT:    invert_r    <= cfg_data[0];
      endcase
    end
  end

  // Arithmetic used by the sequencer steps
  always_comb begin
    sample_sum = sum_r + jsr_pkg::SUM_W'(in_tdata[jsr_pkg::SAMPLE_W-1:0]);
    reading    = jsr_pkg::SAMPLE_W'(sample_sum >> jsr_pkg::SAMPLE_SHIFT);
    cal_add    = cal_sum_r + jsr_pkg::CAL_SUM_W'(reading);
    offset     = $signed({1'b0, reading_r}) - $signed({1'b0, centre_r});
    defl       = offset[jsr_pkg::TRAVEL_W-1] ? jsr_pkg::SAMPLE_W'(-offset)
                                             : jsr_pkg::SAMPLE_W'(offset);
    fault      = (travel_r <= 0);
    moving     = !fault && (defl > {1'b0, dead_zone_r});
    beyond     = defl_r - {1'b0, dead_zone_r};
    range      = (slowest_r >= fastest_r) ? (slowest_r - fastest_r) : '0;
    centre_q   = div_rsp.quotient[jsr_pkg::SAMPLE_W-1:0];
    other      = jsr_pkg::ADC_MAX - centre_q;
    short_side = (centre_q < other) ? centre_q : other;
  end

  // Step the sequencer
  always_comb begin
    state_nxt      = state_r;
    sum_nxt        = sum_r;
    idx_nxt        = idx_r;
    cal_sum_nxt    = cal_sum_r;
    cal_idx_nxt    = cal_idx_r;
    calibrated_nxt = calibrated_r;
    centre_nxt     = centre_r;
    travel_nxt     = travel_r;
    was_moving_nxt = was_moving_r;
    div_cal_nxt    = div_cal_r;
    div_req_nxt    = div_req_r;
    div_req_nxt.start = 1'b0;
    reading_nxt    = reading_r;
    defl_nxt       = defl_r;
    clamped_nxt    = clamped_r;
    mov_nxt        = mov_r;
    fwd_nxt        = fwd_r;
    fault_nxt      = fault_r;
    ivl_nxt        = ivl_r;
    out_load       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (idx_r == jsr_pkg::IDX_W'(jsr_pkg::SAMPLES_PER_READING - 1)) begin
            sum_nxt     = '0;
            idx_nxt     = '0;
            reading_nxt = reading;
            if (calibrated_r) begin
              state_nxt = ST_EVAL;
            end else begin
              cal_sum_nxt = cal_add;
              cal_idx_nxt = cal_idx_r + 1'b1;
              if (cal_idx_r == jsr_pkg::CAL_IDX_W'(jsr_pkg::CAL_READINGS - 1)) begin
                div_req_nxt.start    = 1'b1;
                div_req_nxt.dividend = jsr_pkg::DVD_W'(cal_add);
                div_req_nxt.divisor  = jsr_pkg::DVS_W'(jsr_pkg::CAL_READINGS);
                div_cal_nxt          = 1'b1;
                state_nxt            = ST_DIV;
              end
            end
          end else begin
            sum_nxt = sample_sum;
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      ST_EVAL: begin
        defl_nxt  = defl;
        mov_nxt   = moving;
        fault_nxt = fault;
        fwd_nxt   = moving && ((!offset[jsr_pkg::TRAVEL_W-1] && (offset != 0)) ^ invert_r);
        ivl_nxt   = '0;
        state_nxt = moving ? ST_PREP : ST_WB;
      end
      ST_PREP: begin
        // travel is known positive here, so its low bits hold it
        clamped_nxt = (beyond < {1'b0, travel_r[jsr_pkg::DVS_W-1:0]}) ?
                      beyond[jsr_pkg::DVS_W-1:0] : travel_r[jsr_pkg::DVS_W-1:0];
        state_nxt   = ST_MUL;
      end
      ST_MUL: begin
        div_req_nxt.start    = 1'b1;
        div_req_nxt.dividend = jsr_pkg::DVD_W'(range * clamped_r);
        div_req_nxt.divisor  = travel_r[jsr_pkg::DVS_W-1:0];
        div_cal_nxt          = 1'b0;
        state_nxt            = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          if (div_cal_r) begin
            centre_nxt     = centre_q;
            travel_nxt     = $signed({1'b0, short_side}) - $signed({2'b00, dead_zone_r});
            calibrated_nxt = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            ivl_nxt   = slowest_r - div_rsp.quotient[jsr_pkg::IVL_W-1:0];
            state_nxt = ST_WB;
          end
        end
      end
      ST_WB: begin
        if (!out_valid_r || out_tready) begin
          out_load       = 1'b1;
          was_moving_nxt = mov_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold a result until taken; load the next one behind it
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) out_valid_nxt = 1'b0;
    if (out_load)   out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      sum_r        <= '0;
      idx_r        <= '0;
      cal_sum_r    <= '0;
      cal_idx_r    <= '0;
      calibrated_r <= 1'b0;
      centre_r     <= '0;
      travel_r     <= '0;
      was_moving_r <= 1'b0;
      div_cal_r    <= 1'b0;
      div_req_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sum_r        <= sum_nxt;
      idx_r        <= idx_nxt;
      cal_sum_r    <= cal_sum_nxt;
      cal_idx_r    <= cal_idx_nxt;
      calibrated_r <= calibrated_nxt;
      centre_r     <= centre_nxt;
      travel_r     <= travel_nxt;
      was_moving_r <= was_moving_nxt;
      div_cal_r    <= div_cal_nxt;
      div_req_r    <= div_req_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    reading_r <= reading_nxt;
    defl_r    <= defl_nxt;
    clamped_r <= clamped_nxt;
    mov_r     <= mov_nxt;
    fwd_r     <= fwd_nxt;
    fault_r   <= fault_nxt;
    ivl_r     <= ivl_nxt;
    if (out_load) begin
      out_moving_r <= mov_r;
      out_fwd_r    <= fwd_r;
      out_ivl_r    <= ivl_r;
      out_chg_r    <= mov_r ^ was_moving_r;
      out_fault_r  <= fault_r;
    end
  end

  jsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req_r),
    .rsp   (div_rsp)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_fault_r, out_chg_r, out_ivl_r, out_fwd_r, out_moving_r};

  `JSR_ASSERT_IMP(a_move_no_fault, out_valid_r, !(out_moving_r && out_fault_r), "moving with travel fault")
  `JSR_ASSERT_IMP(a_still_zero, out_valid_r && !out_moving_r, !out_fwd_r && (out_ivl_r == '0), "idle result not zeroed")
  `JSR_ASSERT_NXT(a_cal_sticky, calibrated_r, calibrated_r, "calibration lost")
  `JSR_ASSERT_IMP(a_done_in_div, div_rsp.done, state_r == ST_DIV, "divider finished outside divide step")

endmodule

`default_nettype wire
